FILE: hw/rtl/adsr_pkg.sv
`timescale 1ns / 1ps

package adsr_pkg;

   localparam int LEVEL_WIDTH = 24;
   localparam int REG_WIDTH   = 24;
   localparam int COEF_BITS   = 24;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ATTACK_STEP   = 2'd0,
      CSR_DECAY_COEF    = 2'd1,
      CSR_SUSTAIN_LEVEL = 2'd2,
      CSR_RELEASE_COEF  = 2'd3
   } csr_index_type;

   localparam logic [REG_WIDTH-1:0] ATTACK_STEP_RESET   = 24'd83886;
   localparam logic [REG_WIDTH-1:0] DECAY_COEF_RESET    = 24'd16777;
   localparam logic [REG_WIDTH-1:0] SUSTAIN_LEVEL_RESET = 24'd4194304;
   localparam logic [REG_WIDTH-1:0] RELEASE_COEF_RESET  = 24'd16777;

   typedef struct packed {
      logic [REG_WIDTH-1:0] attack_step;
      logic [REG_WIDTH-1:0] decay_coef;
      logic [REG_WIDTH-1:0] sustain_level;
      logic [REG_WIDTH-1:0] release_coef;
   } cfg_type;

endpackage

FILE: hw/rtl/adsr_core.sv
`timescale 1ns / 1ps

module adsr_core #(
   parameter int FRACTION_BITS = 23
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic                              gate,
   input  adsr_pkg::cfg_type                 cfg,
   output logic [adsr_pkg::LEVEL_WIDTH-1:0]  level_out
);
   import adsr_pkg::*;

   localparam int LW = FRACTION_BITS + 1;
   localparam int DW = ((LW > REG_WIDTH) ? LW : REG_WIDTH) + 3;
   localparam int PW = DW + COEF_BITS + 1;
   localparam longint ONE_L = longint'(1) << FRACTION_BITS;
   localparam longint OV_L  = (ONE_L * 5 + 500) / 1000;
   localparam logic signed [DW-1:0] ONE_D  = DW'(ONE_L);
   localparam logic signed [DW-1:0] OV_D   = DW'(OV_L);
   localparam logic signed [DW-1:0] ZERO_D = '0;

   typedef enum logic [1:0] {
      PH_RELEASE = 2'd0,
      PH_ATTACK  = 2'd1,
      PH_DECAY   = 2'd2,
      PH_SUSTAIN = 2'd3
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [LW-1:0]     level_ff, level_in;

   logic signed [DW-1:0] lvl, sus_raw, sus, atk_sum;
   logic signed [DW-1:0] dec_diff, dec_step, dec_sum;
   logic signed [DW-1:0] rel_base, rel_step, rel_diff;
   logic signed [DW-1:0] next_d;
   logic signed [PW-1:0] dec_prod, rel_prod;

   assign lvl      = $signed(DW'(level_ff));
   assign sus_raw  = $signed(DW'(cfg.sustain_level));
   assign sus      = (sus_raw > ONE_D) ? ONE_D : sus_raw;
   assign atk_sum  = lvl + $signed(DW'(cfg.attack_step));

   assign dec_diff = sus - OV_D - lvl;
   assign dec_prod = $signed(PW'(dec_diff)) * $signed(PW'({1'b0, cfg.decay_coef}));
   assign dec_step = DW'(dec_prod >>> COEF_BITS);
   assign dec_sum  = lvl + dec_step;

   assign rel_base = lvl + OV_D;
   assign rel_prod = $signed(PW'(rel_base)) * $signed(PW'({1'b0, cfg.release_coef}));
   assign rel_step = DW'(rel_prod >>> COEF_BITS);
   assign rel_diff = lvl - rel_step;

   always_comb begin
      phase_in = phase_ff;
      next_d   = lvl;
      if (gate) begin
         unique case (phase_ff)
            PH_RELEASE, PH_ATTACK: begin
               if (atk_sum > ONE_D) begin
                  next_d   = ONE_D;
                  phase_in = PH_DECAY;
               end else begin
                  next_d   = atk_sum;
                  phase_in = PH_ATTACK;
               end
            end
            PH_DECAY: begin
               if (dec_sum < sus) begin
                  next_d   = sus;
                  phase_in = PH_SUSTAIN;
               end else begin
                  next_d   = dec_sum;
               end
            end
            PH_SUSTAIN: begin
               next_d = sus;
            end
            default: begin
               next_d = lvl;
            end
         endcase
      end else begin
         phase_in = PH_RELEASE;
         if (lvl > ZERO_D) begin
            next_d = (rel_diff < ZERO_D) ? ZERO_D : rel_diff;
         end
      end
   end

   assign level_in  = next_d[LW-1:0];
   assign level_out = next_d[LEVEL_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RELEASE;
         level_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         level_ff <= level_in;
      end
   end

endmodule

FILE: hw/rtl/adsr_envelope_generator.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_gate     (1 bit)
// rsp       out        rsp_valid/stall    rsp_level    (24 bits, unsigned)
// csr       in         csr_write          csr_index, csr_wdata (24 bits)
//
// One gate per cycle unless stalled; rsp_valid rises as a result is written.
// A level update is at most one multiply and clamp between the input register
// and the result register; phase and level advance as each result is written.
// Synchronous reset: release phase, level 0, registers at their defaults.
// rsp_stall holds the result register and, once the input register fills, req.

module adsr_envelope_generator #(
   parameter int FRACTION_BITS = 23
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_gate,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [adsr_pkg::LEVEL_WIDTH-1:0]      rsp_level,
   input  logic                                  csr_write,
   input  logic [adsr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [adsr_pkg::REG_WIDTH-1:0]        csr_wdata
);
   import adsr_pkg::*;

   cfg_type                  cfg_ff;
   logic                     in_valid_ff;
   logic                     gate_ff;
   logic                     rsp_valid_ff;
   logic [LEVEL_WIDTH-1:0]   rsp_level_ff;
   logic [LEVEL_WIDTH-1:0]   core_level;
   logic                     advance;
   logic                     req_take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_step   <= ATTACK_STEP_RESET;
         cfg_ff.decay_coef    <= DECAY_COEF_RESET;
         cfg_ff.sustain_level <= SUSTAIN_LEVEL_RESET;
         cfg_ff.release_coef  <= RELEASE_COEF_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_ATTACK_STEP:   cfg_ff.attack_step   <= csr_wdata;
            CSR_DECAY_COEF:    cfg_ff.decay_coef    <= csr_wdata;
            CSR_SUSTAIN_LEVEL: cfg_ff.sustain_level <= csr_wdata;
            CSR_RELEASE_COEF:  cfg_ff.release_coef  <= csr_wdata;
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_take) begin
         gate_ff <= req_gate;
      end
   end

   adsr_core #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .gate      (gate_ff),
      .cfg       (cfg_ff),
      .level_out (core_level)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_level_ff <= core_level;
      end
   end

endmodule
